[hdl/wrist_stillness_and_tilt_controller_core_macros.svh]
// ----------------------------------------------------------------------------
// wrist stillness and tilt controller: assertion macros
// shared concurrent assertion forms, clocked on clk and quiet during rst
// ----------------------------------------------------------------------------
`ifndef WRIST_STILLNESS_AND_TILT_CONTROLLER_CORE_MACROS_SVH
`define WRIST_STILLNESS_AND_TILT_CONTROLLER_CORE_MACROS_SVH

// condition must hold in the same cycle as the trigger
`define WSTC_ASSERT_SAME(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// condition must hold in the cycle after the trigger
`define WSTC_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

[hdl/wstc_pkg.sv]
// ----------------------------------------------------------------------------
// wstc_pkg
// types and constants of the wrist stillness and tilt controller
// ----------------------------------------------------------------------------
package wstc_pkg;

  localparam int WINDOW_DEPTH = 30;
  localparam int SAMPLE_BITS  = 13;
  localparam int IDX_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int DIFF_W       = SAMPLE_BITS + 1;

  localparam int TOL_W        = 13;
  localparam int TRIP_W       = 13;
  localparam int COUNT_W      = 16;
  localparam int SPREAD_W     = 13;
  localparam int CFG_INDEX_W  = 4;

  localparam int IN_DATA_W    = ((1 + SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_PACK_W   = 2 + COUNT_W + SPREAD_W;
  localparam int OUT_DATA_W   = ((OUT_PACK_W + 7) / 8) * 8;

  localparam logic [TOL_W-1:0]         TOLERANCE_RESET = TOL_W'(50);
  localparam logic signed [TRIP_W-1:0] TRIP_RESET      = TRIP_W'(-800);
  localparam logic signed [SAMPLE_BITS-1:0] WIN_RESET_LOW  = SAMPLE_BITS'(-100);
  localparam logic signed [SAMPLE_BITS-1:0] WIN_RESET_HIGH = SAMPLE_BITS'(100);
  localparam logic [SPREAD_W-1:0]      SPREAD_MAX      = '1;

  localparam logic [CFG_INDEX_W-1:0] REG_TOLERANCE = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_TRIP      = CFG_INDEX_W'(1);

  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_TAP  = 2'd1;
  localparam logic [1:0] MODE_TILT = 2'd2;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_SLEPT   = 3'd1,
    EV_WOKE    = 3'd2,
    EV_ARMED   = 3'd3,
    EV_STARTED = 3'd4,
    EV_STOPPED = 3'd5
  } event_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

[hdl/wrist_stillness_and_tilt_controller_core.sv]
// ----------------------------------------------------------------------------
// wrist_stillness_and_tilt_controller_core
// sleep on a still window, wake on tap, stopwatch toggled by a tilt gesture
// ----------------------------------------------------------------------------
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tuser mode, tdata minute_start + accel_x
// m_*       out  m_tvalid/m_tready  tuser event_code, tdata flags/elapsed/spread
// cfg_*     in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// taps, tilts and ticks without a minute start finish in the accept cycle.
// a minute tick writes the sample, then takes one compare step per window entry
// through the shared min/max unit, then loads its result once the output is free.
// the input is not ready while a scan runs or a result waits unaccepted.
// rst is synchronous and loads the window with its start values at once.
// cfg_ready is always high.
`include "wrist_stillness_and_tilt_controller_core_macros.svh"

module wrist_stillness_and_tilt_controller_core
  import wstc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_DATA_W-1:0]   s_tdata,   // minute_start, accel_x, zero fill
  input  logic [1:0]             s_tuser,   // mode
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_DATA_W-1:0]  m_tdata,   // asleep, stopwatch_on, elapsed_seconds,
                                            // window_spread, zero fill
  output logic [2:0]             m_tuser,   // event_code
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [TOL_W-1:0]       cfg_data
);

  state_t state, state_next;

  logic signed [SAMPLE_BITS-1:0] win [WINDOW_DEPTH];
  logic [IDX_W-1:0] pos, pos_next;
  logic [IDX_W-1:0] scan_idx, scan_idx_next;
  logic signed [SAMPLE_BITS-1:0] lo, lo_next, hi, hi_next;

  logic sleeping, sleeping_next;
  logic stopwatch, stopwatch_next;
  logic armed, armed_next;
  logic [COUNT_W-1:0] count, count_next;

  logic [TOL_W-1:0]         tolerance;
  logic signed [TRIP_W-1:0] trip;

  logic                out_asleep, out_sw;
  logic [COUNT_W-1:0]  out_elapsed, out_elapsed_next;
  logic [SPREAD_W-1:0] out_spread, out_spread_next;
  event_t              out_code, out_code_next;
  logic                out_load;

  logic s_accept, out_free, win_we;
  logic minute_in;
  logic signed [SAMPLE_BITS-1:0] x_in, entry;
  logic [COUNT_W-1:0] sw_elapsed, sw_count;
  logic [DIFF_W-1:0] diff;

  assign minute_in = s_tdata[0];
  assign x_in      = $signed(s_tdata[SAMPLE_BITS:1]);
  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == ST_IDLE) && out_free;
  assign s_accept  = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  assign entry = win[scan_idx];
  assign diff  = DIFF_W'($signed({hi[SAMPLE_BITS-1], hi}) - $signed({lo[SAMPLE_BITS-1], lo}));

  // stopwatch step of an awake tick that does not fall asleep
  assign sw_elapsed = stopwatch ? count : '0;
  assign sw_count   = stopwatch ? COUNT_W'(count + 1'b1) : '0;

  always_comb begin
    state_next       = state;
    pos_next         = pos;
    scan_idx_next    = scan_idx;
    lo_next          = lo;
    hi_next          = hi;
    sleeping_next    = sleeping;
    stopwatch_next   = stopwatch;
    armed_next       = armed;
    count_next       = count;
    out_load         = 1'b0;
    out_elapsed_next = '0;
    out_spread_next  = '0;
    out_code_next    = EV_NONE;
    win_we           = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (s_accept) begin
          out_load = 1'b1;
          unique case (s_tuser)
            MODE_TICK: begin
              if (!sleeping) begin
                if (minute_in) begin
                  win_we        = 1'b1;
                  pos_next      = (pos == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : IDX_W'(pos + 1'b1);
                  scan_idx_next = '0;
                  out_load      = 1'b0;
                  state_next    = ST_SCAN;
                end else begin
                  out_elapsed_next = sw_elapsed;
                  count_next       = sw_count;
                end
              end
            end
            MODE_TAP: begin
              if (sleeping) begin
                sleeping_next = 1'b0;
                out_code_next = EV_WOKE;
              end else begin
                armed_next    = 1'b1;
                out_code_next = EV_ARMED;
              end
            end
            MODE_TILT: begin
              if (armed) begin
                if (x_in < trip) begin
                  stopwatch_next = !stopwatch;
                  out_code_next  = stopwatch ? EV_STOPPED : EV_STARTED;
                end
                armed_next = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_idx == '0) begin
          lo_next = entry;
          hi_next = entry;
        end else begin
          lo_next = (entry < lo) ? entry : lo;
          hi_next = (entry > hi) ? entry : hi;
        end
        if (scan_idx == IDX_W'(WINDOW_DEPTH - 1)) begin
          state_next = ST_FINISH;
        end else begin
          scan_idx_next = IDX_W'(scan_idx + 1'b1);
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_spread_next = (diff > DIFF_W'(SPREAD_MAX)) ? SPREAD_MAX : SPREAD_W'(diff);
          if (diff < DIFF_W'(tolerance)) begin
            sleeping_next = 1'b1;
            out_code_next = EV_SLEPT;
          end else begin
            out_elapsed_next = sw_elapsed;
            count_next       = sw_count;
          end
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      sleeping  <= 1'b0;
      stopwatch <= 1'b0;
      armed     <= 1'b0;
      count     <= '0;
      m_tvalid  <= 1'b0;
      tolerance <= TOLERANCE_RESET;
      trip      <= TRIP_RESET;
    end else begin
      pos       <= pos_next;
      sleeping  <= sleeping_next;
      stopwatch <= stopwatch_next;
      armed     <= armed_next;
      count     <= count_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_TOLERANCE) begin
          tolerance <= cfg_data;
        end else if (cfg_index == REG_TRIP) begin
          trip <= $signed(cfg_data);
        end
      end
    end
  end

  // window store with its start pattern
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        if (i == 1) begin
          win[i] <= WIN_RESET_LOW;
        end else if (i == 2) begin
          win[i] <= WIN_RESET_HIGH;
        end else begin
          win[i] <= '0;
        end
      end
    end else if (win_we) begin
      win[pos] <= x_in;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    scan_idx <= scan_idx_next;
    lo       <= lo_next;
    hi       <= hi_next;
    if (out_load) begin
      out_asleep  <= sleeping_next;
      out_sw      <= stopwatch_next;
      out_elapsed <= out_elapsed_next;
      out_spread  <= out_spread_next;
      out_code    <= out_code_next;
    end
  end

  assign m_tdata = {{(OUT_DATA_W - OUT_PACK_W){1'b0}},
                    out_spread, out_elapsed, out_sw, out_asleep};
  assign m_tuser = out_code;

  `WSTC_ASSERT_SAME(a_ready_only_idle, s_tready, state == ST_IDLE,
                    "input ready outside idle")
  `WSTC_ASSERT_SAME(a_scan_in_range, state == ST_SCAN,
                    scan_idx <= IDX_W'(WINDOW_DEPTH - 1), "scan index past window")
  `WSTC_ASSERT_NEXT(a_minute_scans,
                    s_accept && (s_tuser == MODE_TICK) && minute_in && !sleeping,
                    (state == ST_SCAN) && (scan_idx == '0) && !m_tvalid,
                    "minute tick did not start a scan")
  `WSTC_ASSERT_SAME(a_sleep_reported, $rose(sleeping),
                    m_tvalid && (out_code == EV_SLEPT) && out_asleep,
                    "sleep entered without a slept word")

endmodule
